[rtl/sjf_pkg.sv]
package sjf_pkg;

   localparam int MAX_PROCESSES_DEF = 16;

   localparam int BURST_W = 16;
   localparam int PID_W   = 5;
   localparam int TIME_W  = 20;
   localparam int WTOT_W  = 23;
   localparam int TTOT_W  = 24;
   localparam int ALU_W   = 24;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SRD_X,
      ST_SLD_X,
      ST_SRD_Y,
      ST_SCMP,
      ST_SWB,
      ST_ERD,
      ST_EADD1,
      ST_EADD2,
      ST_EADD3,
      ST_EOUT
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_CMP
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             gt;
   } alu_rsp_type;

endpackage

[rtl/sjf_ram.sv]
module sjf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sjf_alu.sv]
module sjf_alu (
   input  sjf_pkg::alu_req_type req,
   output sjf_pkg::alu_rsp_type rsp
);
   import sjf_pkg::*;

   logic [ALU_W-1:0] b_op;
   logic [ALU_W:0]   full;

   always_comb begin
      b_op    = (req.op == ALU_CMP) ? ~req.b : req.b;
      full    = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, (req.op == ALU_CMP)};
      rsp.sum = full[ALU_W-1:0];
      // carry out means a >= b; nonzero difference makes it strict
      rsp.gt  = full[ALU_W] && (full[ALU_W-1:0] != '0);
   end

endmodule

[rtl/sjf_schedule_wait_times.sv]
// channel  | direction | ports                                    | handshake
// req      | in        | req_burst_time, req_last                 | req_valid / req_stall
// rsp      | out       | rsp_process_id .. rsp_last_out           | rsp_valid / rsp_stall
//
// loading accepts one item per cycle; req_stall is low only while loading
// the sort reuses one adder/comparator: for each position x it reads and loads x,
// then reads and compares each later entry, then writes the smallest back to x
// each result then steps through a read, three adds and the output, held while rsp_stall is high
// synchronous reset clears the count, drop flag, sums and sequencer state
module sjf_schedule_wait_times #(
   parameter int MAX_PROCESSES = sjf_pkg::MAX_PROCESSES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sjf_pkg::BURST_W-1:0]  req_burst_time,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sjf_pkg::PID_W-1:0]    rsp_process_id,
   output logic [sjf_pkg::TIME_W-1:0]   rsp_wait_time,
   output logic [sjf_pkg::TIME_W-1:0]   rsp_turnaround_time,
   output logic [sjf_pkg::WTOT_W-1:0]   rsp_total_wait,
   output logic [sjf_pkg::TTOT_W-1:0]   rsp_total_turnaround,
   output logic                         rsp_dropped,
   output logic                         rsp_last_out
);
   import sjf_pkg::*;

   localparam int AW  = $clog2(MAX_PROCESSES);
   localparam int CW  = $clog2(MAX_PROCESSES + 1);
   localparam int IDW = AW;
   localparam int EW  = BURST_W + IDW;

   state_type state_ff, state_in;

   logic [CW-1:0]     cnt_ff;
   logic              ovf_ff;
   logic [AW-1:0]     x_ff, y_ff, k_ff;
   logic [EW-1:0]     cur_ff, ent_ff;
   logic [TIME_W-1:0] elapsed_ff, wt_ff, tat_ff;
   logic [WTOT_W-1:0] wtot_ff;
   logic [TTOT_W-1:0] ttot_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic          req_take, rsp_take;
   logic          has_room;
   logic          x_end, y_end, k_end;
   logic [IDW:0]  pid_full;

   sjf_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_PROCESSES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sjf_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign has_room = cnt_ff < CW'(MAX_PROCESSES);
   assign x_end    = (CW'(x_ff) + CW'(1)) == cnt_ff;
   assign y_end    = (CW'(y_ff) + CW'(1)) == cnt_ff;
   assign k_end    = (CW'(k_ff) + CW'(1)) == cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:  if (req_take && req_last) state_in = ST_SRD_X;
         ST_SRD_X: state_in = ST_SLD_X;
         ST_SLD_X: state_in = x_end ? ST_ERD : ST_SRD_Y;
         ST_SRD_Y: state_in = ST_SCMP;
         ST_SCMP:  state_in = y_end ? ST_SWB : ST_SRD_Y;
         ST_SWB:   state_in = ST_SRD_X;
         ST_ERD:   state_in = ST_EADD1;
         ST_EADD1: state_in = ST_EADD2;
         ST_EADD2: state_in = ST_EADD3;
         ST_EADD3: state_in = ST_EOUT;
         ST_EOUT:  if (rsp_take) state_in = rsp_last_out ? ST_LOAD : ST_ERD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = x_ff;
      wr_data   = cur_ff;
      rd_addr   = x_ff;
      alu_req   = '{op: ALU_ADD, a: '0, b: '0};
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            wr_en     = req_take && has_room;
            wr_addr   = cnt_ff[AW-1:0];
            wr_data   = {cnt_ff[AW-1:0], req_burst_time};
         end
         ST_SRD_X: rd_addr = x_ff;
         ST_SRD_Y: rd_addr = y_ff;
         ST_SCMP: begin
            alu_req = '{op: ALU_CMP,
                        a: ALU_W'(cur_ff[BURST_W-1:0]),
                        b: ALU_W'(rd_data[BURST_W-1:0])};
            wr_en   = alu_rsp.gt;
            wr_addr = y_ff;
            wr_data = cur_ff;
         end
         ST_SWB: begin
            wr_en   = 1'b1;
            wr_addr = x_ff;
            wr_data = cur_ff;
         end
         ST_ERD: rd_addr = k_ff;
         ST_EADD1: alu_req = '{op: ALU_ADD, a: ALU_W'(elapsed_ff),
                               b: ALU_W'(rd_data[BURST_W-1:0])};
         ST_EADD2: alu_req = '{op: ALU_ADD, a: ALU_W'(wtot_ff), b: ALU_W'(wt_ff)};
         ST_EADD3: alu_req = '{op: ALU_ADD, a: ALU_W'(ttot_ff), b: ALU_W'(tat_ff)};
         ST_EOUT:  rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         x_ff       <= '0;
         y_ff       <= '0;
         k_ff       <= '0;
         elapsed_ff <= '0;
         wtot_ff    <= '0;
         ttot_ff    <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_LOAD: begin
               if (req_take) begin
                  if (has_room) cnt_ff <= cnt_ff + CW'(1);
                  else          ovf_ff <= 1'b1;
               end
               x_ff <= '0;
            end
            ST_SLD_X: begin
               cur_ff     <= rd_data;
               y_ff       <= x_ff + AW'(1);
               k_ff       <= '0;
               elapsed_ff <= '0;
               wtot_ff    <= '0;
               ttot_ff    <= '0;
            end
            ST_SCMP: begin
               if (alu_rsp.gt) cur_ff <= rd_data;
               y_ff <= y_ff + AW'(1);
            end
            ST_SWB: x_ff <= x_ff + AW'(1);
            ST_EADD1: begin
               ent_ff     <= rd_data;
               wt_ff      <= elapsed_ff;
               tat_ff     <= TIME_W'(alu_rsp.sum);
               elapsed_ff <= TIME_W'(alu_rsp.sum);
            end
            ST_EADD2: wtot_ff <= WTOT_W'(alu_rsp.sum);
            ST_EADD3: ttot_ff <= TTOT_W'(alu_rsp.sum);
            ST_EOUT: begin
               if (rsp_take) begin
                  if (k_end) begin
                     cnt_ff     <= '0;
                     ovf_ff     <= 1'b0;
                     elapsed_ff <= '0;
                     wtot_ff    <= '0;
                     ttot_ff    <= '0;
                  end else begin
                     k_ff <= k_ff + AW'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign pid_full             = {1'b0, ent_ff[EW-1:BURST_W]} + (IDW+1)'(1);
   assign rsp_process_id       = PID_W'(pid_full);
   assign rsp_wait_time        = wt_ff;
   assign rsp_turnaround_time  = tat_ff;
   assign rsp_total_wait       = wtot_ff;
   assign rsp_total_turnaround = ttot_ff;
   assign rsp_dropped          = ovf_ff;
   assign rsp_last_out         = k_end;

endmodule

[rtl/sjf_checker.sv]
module sjf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [sjf_pkg::PID_W-1:0]   rsp_process_id,
   input logic [sjf_pkg::TIME_W-1:0]  rsp_wait_time,
   input logic [sjf_pkg::TIME_W-1:0]  rsp_turnaround_time,
   input logic                        rsp_last_out
);

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item taken while a result is pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_process_id)
         && $stable(rsp_wait_time) && $stable(rsp_turnaround_time)
         && $stable(rsp_last_out))
      else $error("stalled result changed");

   a_busy_after_last_in: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall && !rsp_valid)
      else $error("not busy after last item");

   a_busy_mid_schedule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_out |=> req_stall && !rsp_valid)
      else $error("schedule ended early");

   a_idle_after_schedule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_out |=> !req_stall && !rsp_valid)
      else $error("not ready after final result");

endmodule

bind sjf_schedule_wait_times sjf_checker u_sjf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_last            (req_last),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_process_id      (rsp_process_id),
   .rsp_wait_time       (rsp_wait_time),
   .rsp_turnaround_time (rsp_turnaround_time),
   .rsp_last_out        (rsp_last_out)
);

[tb/sjf_schedule_wait_times_tb.sv]
module sjf_schedule_wait_times_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sjf_pkg::*;

   localparam int MAX_PROC    = MAX_PROCESSES_DEF;
   localparam int DIR_ROWS    = 25;
   localparam int RAND_ITEMS  = 335;
   localparam int LONG_HOLD   = 400;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 60;
   localparam int MAX_PRINTS  = 100;

   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] wait_t;
      logic [TIME_W-1:0] tat;
      logic [WTOT_W-1:0] wait_sum;
      logic [TTOT_W-1:0] tat_sum;
      logic              dropped;
      logic              fin;
   } sched_type;

   typedef struct {
      logic [BURST_W-1:0] burst;
      logic               fin;
      logic               typed;
      sched_type          fixed;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BURST_W-1:0]  req_burst_time = '0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PID_W-1:0]    rsp_process_id;
   logic [TIME_W-1:0]   rsp_wait_time;
   logic [TIME_W-1:0]   rsp_turnaround_time;
   logic [WTOT_W-1:0]   rsp_total_wait;
   logic [TTOT_W-1:0]   rsp_total_turnaround;
   logic                rsp_dropped;
   logic                rsp_last_out;

   // known result riding along with a directed item
   logic                row_typed = 1'b0;
   sched_type           row_fixed = '0;

   logic [BURST_W-1:0]  held_burst [MAX_PROC];
   int                  held_id [MAX_PROC];
   int                  held_count = 0;
   logic                held_over = 1'b0;
   sched_type           schedule_q [$];

   stim_row_type        dir_tab [DIR_ROWS];
   int                  mismatches = 0;
   int                  items_taken = 0;
   int                  sets_done = 0;
   int                  sets_dropped = 0;
   int                  results_seen = 0;
   int                  quiet_cycles = 0;
   bit                  steady = 1'b0;
   bit                  long_hold_done = 1'b0;

   sjf_schedule_wait_times #(.MAX_PROCESSES(MAX_PROC)) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_burst_time       (req_burst_time),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_process_id       (rsp_process_id),
      .rsp_wait_time        (rsp_wait_time),
      .rsp_turnaround_time  (rsp_turnaround_time),
      .rsp_total_wait       (rsp_total_wait),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_dropped          (rsp_dropped),
      .rsp_last_out         (rsp_last_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic note_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
         $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
   endtask

   // store one process, and on the last one build its whole schedule
   task automatic admit_process(input logic [BURST_W-1:0] burst, input logic fin,
                                input logic typed, input sched_type fixed);
      logic [BURST_W-1:0] swap_burst;
      int                 swap_id;
      logic [TIME_W-1:0]  elapsed;
      logic [TIME_W-1:0]  wt;
      logic [TIME_W-1:0]  tat;
      logic [WTOT_W-1:0]  wait_sum;
      logic [TTOT_W-1:0]  tat_sum;
      sched_type          r;
      items_taken++;
      if (held_count < MAX_PROC) begin
         held_burst[held_count] = burst;
         held_id[held_count] = held_count;
         held_count++;
      end else begin
         held_over = 1'b1;
      end
      if (fin) begin
         for (int x = 0; x < held_count; x++) begin
            for (int y = x; y < held_count; y++) begin
               if (held_burst[x] > held_burst[y]) begin
                  swap_burst = held_burst[x];
                  swap_id = held_id[x];
                  held_burst[x] = held_burst[y];
                  held_id[x] = held_id[y];
                  held_burst[y] = swap_burst;
                  held_id[y] = swap_id;
               end
            end
         end
         elapsed = '0;
         wait_sum = '0;
         tat_sum = '0;
         for (int k = 0; k < held_count; k++) begin
            wt = elapsed;
            tat = wt + TIME_W'(held_burst[k]);
            elapsed = tat;
            wait_sum = wait_sum + WTOT_W'(wt);
            tat_sum = tat_sum + TTOT_W'(tat);
            r.pid = PID_W'(held_id[k] + 1);
            r.wait_t = wt;
            r.tat = tat;
            r.wait_sum = wait_sum;
            r.tat_sum = tat_sum;
            r.dropped = held_over;
            r.fin = (k == held_count - 1);
            schedule_q.push_back(typed ? fixed : r);
         end
         sets_done++;
         if (held_over) sets_dropped++;
         held_count = 0;
         held_over = 1'b0;
      end
   endtask

   task automatic check_result();
      sched_type want;
      results_seen++;
      if (schedule_q.size() == 0) begin
         note_mismatch("result with none pending", rsp_process_id, 0);
      end else begin
         want = schedule_q.pop_front();
         if (rsp_process_id !== want.pid)
            note_mismatch("process_id", rsp_process_id, want.pid);
         if (rsp_wait_time !== want.wait_t)
            note_mismatch("wait_time", rsp_wait_time, want.wait_t);
         if (rsp_turnaround_time !== want.tat)
            note_mismatch("turnaround_time", rsp_turnaround_time, want.tat);
         if (rsp_total_wait !== want.wait_sum)
            note_mismatch("total_wait", rsp_total_wait, want.wait_sum);
         if (rsp_total_turnaround !== want.tat_sum)
            note_mismatch("total_turnaround", rsp_total_turnaround, want.tat_sum);
         if (rsp_dropped !== want.dropped)
            note_mismatch("dropped", rsp_dropped, want.dropped);
         if (rsp_last_out !== want.fin)
            note_mismatch("last_out", rsp_last_out, want.fin);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) admit_process(req_burst_time, req_last, row_typed, row_fixed);
         if (rsp_valid && !rsp_stall) check_result();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [BURST_W-1:0] burst, input logic fin,
                            input logic typed, input sched_type fixed);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_burst_time <= burst;
      req_last <= fin;
      row_typed <= typed;
      row_fixed <= fixed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver: random hold-offs, one long one so the input backs up
   initial begin
      while (reset) @(posedge clock);
      while (!steady) begin
         if (!long_hold_done && results_seen >= 30) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
      rsp_stall <= 1'b0;
   end

   initial begin
      int                 rand_items;
      int                 pick;
      int                 set_len;
      int                 style;
      logic [BURST_W-1:0] base;
      logic [BURST_W-1:0] b;
      rand_items = 0;

      // single-process sets at both burst extremes
      dir_tab[0] = '{16'h0000, 1'b1, 1'b1, '{5'd1, 20'd0, 20'd0, 23'd0, 24'd0, 1'b0, 1'b1}};
      dir_tab[1] = '{16'hFFFF, 1'b1, 1'b1,
                     '{5'd1, 20'd0, 20'd65535, 23'd0, 24'd65535, 1'b0, 1'b1}};
      // equal bursts
      dir_tab[2] = '{16'd7, 1'b0, 1'b0, '0};
      dir_tab[3] = '{16'd7, 1'b0, 1'b0, '0};
      dir_tab[4] = '{16'd7, 1'b1, 1'b0, '0};
      // ties split by a shorter job
      dir_tab[5] = '{16'd40000, 1'b0, 1'b0, '0};
      dir_tab[6] = '{16'd9, 1'b0, 1'b0, '0};
      dir_tab[7] = '{16'd40000, 1'b1, 1'b0, '0};
      // full store of maximum bursts, the last one dropped
      for (int i = 8; i < DIR_ROWS; i++) dir_tab[i] = '{16'hFFFF, 1'b0, 1'b0, '0};
      dir_tab[DIR_ROWS-1].fin = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_item(dir_tab[i].burst, dir_tab[i].fin, dir_tab[i].typed, dir_tab[i].fixed);
      end

      while (rand_items < RAND_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) set_len = $urandom_range(2, 8);
         else if (pick == 7) set_len = 1;
         else if (pick == 8) set_len = MAX_PROC;
         else set_len = $urandom_range(MAX_PROC + 1, MAX_PROC + 4);
         style = $urandom_range(0, 3);
         base = BURST_W'($urandom);
         for (int n = 0; n < set_len; n++) begin
            case (style)
               0: b = BURST_W'($urandom_range(0, 15));
               1: b = BURST_W'($urandom);
               2: b = base;
               default: b = $urandom_range(0, 1) ? '1 : '0;
            endcase
            send_item(b, n == set_len - 1, 1'b0, '0);
            rand_items++;
            if (rand_items >= RAND_ITEMS * 5 / 6) steady = 1'b1;
         end
      end
      req_valid <= 1'b0;

      // let the last item reach the predictor before watching the queue
      @(posedge clock);
      while (schedule_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d processes in %0d sets (%0d with drops), %0d results checked",
               items_taken, sets_done, sets_dropped, results_seen);
      $display("mismatches seen: %0d", mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
